// ----- rtl/apea_pkg.sv -----
// Shared types, codes and helpers for the absolute pointer event accumulator.
`timescale 1ns / 1ps
`default_nettype none
package apea_pkg;

	localparam logic [15:0] TYPE_SYN        = 16'h0000;
	localparam logic [15:0] TYPE_KEY        = 16'h0001;
	localparam logic [15:0] TYPE_ABS        = 16'h0003;
	localparam logic [15:0] CODE_AXIS_X     = 16'h0000;
	localparam logic [15:0] CODE_AXIS_Y     = 16'h0001;
	localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;
	localparam logic [15:0] CODE_BTN_LEFT   = 16'h0110;
	localparam logic [15:0] CODE_BTN_RIGHT  = 16'h0111;
	localparam logic [15:0] CODE_BTN_MIDDLE = 16'h0112;

	localparam logic [2:0] BTN_LEFT_BIT   = 3'b001;
	localparam logic [2:0] BTN_RIGHT_BIT  = 3'b010;
	localparam logic [2:0] BTN_MIDDLE_BIT = 3'b100;

	localparam logic CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic CFG_SCREEN_HEIGHT = 1'b1;

	localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd1024;
	localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd768;

	localparam logic [15:0] AXIS_FULL_SCALE = 16'd32767;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef logic [QUEUE_AW-1:0] queue_ptr_t;
	typedef logic [QUEUE_AW:0]   queue_cnt_t;

	typedef struct packed {
		logic        use_raw;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] dm1_x;
		logic [15:0] dm1_y;
		logic [2:0]  buttons;
	} report_t;

	function automatic logic [15:0] dim_minus_one(input logic [15:0] dim);
		return (dim <= 16'd1) ? 16'd1 : dim - 16'd1;
	endfunction

	function automatic logic [31:0] magnitude(input logic [31:0] pos);
		return pos[31] ? (~pos + 32'd1) : pos;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/apea_front.sv -----
// Front end: configuration registers, event decode and pointer state.
`timescale 1ns / 1ps
`default_nettype none
module apea_front import apea_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] event_type,
	input  wire logic [15:0] event_code,
	input  wire logic [31:0] event_value,
	input  wire logic [31:0] cursor_now_x,
	input  wire logic [31:0] cursor_now_y,
	input  wire logic        queue_full,
	output logic             push,
	output report_t          push_data
);

	logic [15:0] screen_width_q;
	logic [15:0] screen_height_q;
	logic [31:0] pos_x_q;
	logic [31:0] pos_y_q;
	logic        pos_valid_q;
	logic [2:0]  buttons_q;
	logic        accept;
	logic [2:0]  key_bit;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_comb begin
		case (event_code)
			CODE_BTN_LEFT:   key_bit = BTN_LEFT_BIT;
			CODE_BTN_RIGHT:  key_bit = BTN_RIGHT_BIT;
			CODE_BTN_MIDDLE: key_bit = BTN_MIDDLE_BIT;
			default:         key_bit = 3'b000;
		endcase
	end

	assign push = accept && (event_type == TYPE_SYN) && (event_code == CODE_SYN_REPORT);

	always_comb begin
		push_data.use_raw = !pos_valid_q;
		push_data.x       = pos_valid_q ? pos_x_q : cursor_now_x;
		push_data.y       = pos_valid_q ? pos_y_q : cursor_now_y;
		push_data.dm1_x   = dim_minus_one(screen_width_q);
		push_data.dm1_y   = dim_minus_one(screen_height_q);
		push_data.buttons = buttons_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default:           screen_width_q  <= screen_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_valid_q <= 1'b0;
			buttons_q   <= '0;
		end else if (accept) begin
			if (event_type == TYPE_ABS) begin
				if (event_code == CODE_AXIS_X) begin
					pos_x_q     <= event_value;
					pos_valid_q <= 1'b1;
				end else if (event_code == CODE_AXIS_Y) begin
					pos_y_q     <= event_value;
					pos_valid_q <= 1'b1;
				end
			end else if (event_type == TYPE_KEY) begin
				if (event_value != 32'd0) begin
					buttons_q <= buttons_q | key_bit;
				end else begin
					buttons_q <= buttons_q & ~key_bit;
				end
			end
		end
	end

	apea_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("report pushed into a full queue");

endmodule
`default_nettype wire

// ----- rtl/apea_queue.sv -----
// Short report queue between the decode front end and the scaling back end.
`timescale 1ns / 1ps
`default_nettype none
module apea_queue import apea_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire report_t push_data,
	input  wire logic    pop,
	output report_t      pop_data,
	output logic         full,
	output logic         empty
);

	report_t    mem [QUEUE_DEPTH];
	queue_ptr_t wr_ptr_q;
	queue_ptr_t rd_ptr_q;
	queue_cnt_t count_q;

	assign full     = (count_q == queue_cnt_t'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + queue_ptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + queue_ptr_t'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + queue_cnt_t'(1);
				2'b01:   count_q <= count_q - queue_cnt_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	apea_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("report popped from an empty queue");

	apea_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= queue_cnt_t'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/apea_scale.sv -----
// Back end: scales stored positions to the screen and holds the output transaction.
`timescale 1ns / 1ps
`default_nettype none
module apea_scale import apea_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        queue_empty,
	input  wire report_t     queue_data,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pointer_x,
	output logic [31:0]      pointer_y,
	output logic [2:0]       button_mask
);

	typedef struct packed {
		logic        use_raw;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] raw_x;
		logic [31:0] raw_y;
		logic [2:0]  buttons;
	} side_t;

	logic        en;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [31:0] mag_x_s1, mag_y_s1;
	logic [15:0] dm1_x_s1, dm1_y_s1;
	logic [47:0] prod_x_s2, prod_y_s2;
	logic [32:0] h_x_s3, h_y_s3;
	logic [33:0] sum1_x_s3, sum1_y_s3;
	logic [32:0] qa_x_s4, qa_y_s4;
	logic [19:0] sum2_x_s4, sum2_y_s4;
	logic [32:0] q_x_s5, q_y_s5;
	logic [15:0] sum3_x, sum3_y;
	logic [31:0] res_x, res_y;
	logic        out_valid_q;
	logic [31:0] pointer_x_q;
	logic [31:0] pointer_y_q;
	logic [2:0]  button_mask_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !queue_empty;

	assign sum3_x = 16'(sum2_x_s4[19:15]) + 16'(sum2_x_s4[14:0]);
	assign sum3_y = 16'(sum2_y_s4[19:15]) + 16'(sum2_y_s4[14:0]);

	assign res_x = side_s5.neg_x ? (~q_x_s5[31:0] + 32'd1) : q_x_s5[31:0];
	assign res_y = side_s5.neg_y ? (~q_y_s5[31:0] + 32'd1) : q_y_s5[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.use_raw <= queue_data.use_raw;
			side_s1.neg_x   <= queue_data.x[31];
			side_s1.neg_y   <= queue_data.y[31];
			side_s1.raw_x   <= queue_data.x;
			side_s1.raw_y   <= queue_data.y;
			side_s1.buttons <= queue_data.buttons;
			mag_x_s1        <= magnitude(queue_data.x);
			mag_y_s1        <= magnitude(queue_data.y);
			dm1_x_s1        <= queue_data.dm1_x;
			dm1_y_s1        <= queue_data.dm1_y;

			side_s2   <= side_s1;
			prod_x_s2 <= 48'(mag_x_s1) * 48'(dm1_x_s1);
			prod_y_s2 <= 48'(mag_y_s1) * 48'(dm1_y_s1);

			// fold 2^15 = 32767 + 1: m / 32767 = hi + (hi + lo) / 32767
			side_s3   <= side_s2;
			h_x_s3    <= prod_x_s2[47:15];
			h_y_s3    <= prod_y_s2[47:15];
			sum1_x_s3 <= 34'(prod_x_s2[47:15]) + 34'(prod_x_s2[14:0]);
			sum1_y_s3 <= 34'(prod_y_s2[47:15]) + 34'(prod_y_s2[14:0]);

			side_s4   <= side_s3;
			qa_x_s4   <= h_x_s3 + 33'(sum1_x_s3[33:15]);
			qa_y_s4   <= h_y_s3 + 33'(sum1_y_s3[33:15]);
			sum2_x_s4 <= 20'(sum1_x_s3[33:15]) + 20'(sum1_x_s3[14:0]);
			sum2_y_s4 <= 20'(sum1_y_s3[33:15]) + 20'(sum1_y_s3[14:0]);

			side_s5 <= side_s4;
			q_x_s5  <= qa_x_s4 + 33'(sum2_x_s4[19:15])
				+ 33'(sum3_x >= AXIS_FULL_SCALE);
			q_y_s5  <= qa_y_s4 + 33'(sum2_y_s4[19:15])
				+ 33'(sum3_y >= AXIS_FULL_SCALE);

			pointer_x_q   <= side_s5.use_raw ? side_s5.raw_x : res_x;
			pointer_y_q   <= side_s5.use_raw ? side_s5.raw_y : res_y;
			button_mask_q <= side_s5.buttons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !queue_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	assign out_valid   = out_valid_q;
	assign pointer_x   = pointer_x_q;
	assign pointer_y   = pointer_y_q;
	assign button_mask = button_mask_q;

	apea_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(v_s5) && $stable(v_s1) && !$past(pop)))
		else $error("back end advanced while output stalled");

endmodule
`default_nettype wire

// ----- rtl/abs_pointer_event_accumulator.sv -----
// Top level: absolute pointer event accumulator.
// Throughput: one event per cycle while the output is not stalled.
// A sync report is registered in order through the queue write, then magnitude, multiply,
// three fold steps and the output register; a stall holds it in place.
// Events that give no result only update state and occupy no back-end slot.
// Reset: asynchronous, clears position, buttons, queue and pipeline; screen 1024 x 768.
`timescale 1ns / 1ps
`default_nettype none
module abs_pointer_event_accumulator import apea_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] event_type,
	input  wire logic [15:0] event_code,
	input  wire logic [31:0] event_value,
	input  wire logic [31:0] cursor_now_x,
	input  wire logic [31:0] cursor_now_y,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pointer_x,
	output logic [31:0]      pointer_y,
	output logic [2:0]       button_mask
);

	logic    q_push;
	logic    q_pop;
	logic    q_full;
	logic    q_empty;
	report_t push_data;
	report_t pop_data;

	apea_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.event_type   (event_type),
		.event_code   (event_code),
		.event_value  (event_value),
		.cursor_now_x (cursor_now_x),
		.cursor_now_y (cursor_now_y),
		.queue_full   (q_full),
		.push         (q_push),
		.push_data    (push_data)
	);

	apea_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	apea_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.queue_data  (pop_data),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pointer_x   (pointer_x),
		.pointer_y   (pointer_y),
		.button_mask (button_mask)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_abs_pointer_event_accumulator.sv -----
// Self-checking testbench for the absolute pointer event accumulator.
`timescale 1ns / 1ps
module tb_abs_pointer_event_accumulator;
	import apea_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int PHASES       = 8;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [2:0]  buttons;
	} pointer_report_t;

	class pointer_tracker;
		logic [15:0]     width;
		logic [15:0]     height;
		logic [31:0]     pos_x;
		logic [31:0]     pos_y;
		bit              pos_valid;
		logic [2:0]      buttons;
		pointer_report_t reports_due[$];
		int              errors;

		function new();
			width     = SCREEN_WIDTH_RST;
			height    = SCREEN_HEIGHT_RST;
			pos_x     = '0;
			pos_y     = '0;
			pos_valid = 1'b0;
			buttons   = '0;
			errors    = 0;
		endfunction

		function void set_screen(logic [15:0] w, logic [15:0] h);
			width  = w;
			height = h;
		endfunction

		function int pending();
			return reports_due.size();
		endfunction

		// signed 64-bit product, quotient truncated toward zero, low 32 bits kept
		function logic [31:0] scale_to_screen(logic [31:0] pos, logic [15:0] dim);
			longint      span;
			longint      prod;
			logic [63:0] quot;
			span = (dim <= 16'd1) ? 64'sd1 : longint'(dim) - 64'sd1;
			prod = longint'($signed(pos)) * span;
			quot = prod / 64'sd32767;
			return quot[31:0];
		endfunction

		function void note_event(logic [15:0] etype, logic [15:0] ecode,
			logic [31:0] value, logic [31:0] cx, logic [31:0] cy);
			logic [2:0]      btn;
			pointer_report_t r;
			case (etype)
				TYPE_ABS: begin
					if (ecode == CODE_AXIS_X) begin
						pos_x     = value;
						pos_valid = 1'b1;
					end else if (ecode == CODE_AXIS_Y) begin
						pos_y     = value;
						pos_valid = 1'b1;
					end
				end
				TYPE_KEY: begin
					btn = (ecode == CODE_BTN_LEFT)   ? BTN_LEFT_BIT :
					      (ecode == CODE_BTN_RIGHT)  ? BTN_RIGHT_BIT :
					      (ecode == CODE_BTN_MIDDLE) ? BTN_MIDDLE_BIT : 3'b000;
					if (btn != 3'b000)
						buttons = (value != 32'd0) ? (buttons | btn) : (buttons & ~btn);
				end
				TYPE_SYN: begin
					if (ecode == CODE_SYN_REPORT) begin
						if (pos_valid) begin
							r.x = scale_to_screen(pos_x, width);
							r.y = scale_to_screen(pos_y, height);
						end else begin
							r.x = cx;
							r.y = cy;
						end
						r.buttons = buttons;
						reports_due.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
			errors++;
		endtask

		task check_report(logic [31:0] x, logic [31:0] y, logic [2:0] btn);
			pointer_report_t r;
			if (reports_due.size() == 0) begin
				report_mismatch("report with none due", x, '0);
			end else begin
				r = reports_due.pop_front();
				if (x !== r.x)
					report_mismatch("pointer_x", x, r.x);
				if (y !== r.y)
					report_mismatch("pointer_y", y, r.y);
				if (btn !== r.buttons)
					report_mismatch("button_mask", {29'd0, btn}, {29'd0, r.buttons});
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] event_type;
	logic [15:0] event_code;
	logic [31:0] event_value;
	logic [31:0] cursor_now_x;
	logic [31:0] cursor_now_y;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] pointer_x;
	logic [31:0] pointer_y;
	logic [2:0]  button_mask;

	pointer_tracker sb = new();
	int             cycle_count = 0;
	int             items_sent  = 0;
	bit             tx_steady   = 1'b0;
	bit             rx_steady   = 1'b0;
	int             rx_hold     = 0;

	abs_pointer_event_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.event_type   (event_type),
		.event_code   (event_code),
		.event_value  (event_value),
		.cursor_now_x (cursor_now_x),
		.cursor_now_y (cursor_now_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pointer_x    (pointer_x),
		.pointer_y    (pointer_y),
		.button_mask  (button_mask)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int draw_wait(bit steady);
		if (steady)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
	endfunction

	// result side: check each transaction, then stall for a drawn number of cycles
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_report(pointer_x, pointer_y, button_mask);
				if ($urandom_range(0, 40) == 0)
					rx_steady = !rx_steady;
				rx_hold = draw_wait(rx_steady);
				out_stall <= (rx_hold > 0);
			end else if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= (rx_hold > 0);
			end
		end
	end

	task automatic send_event(input logic [15:0] etype, input logic [15:0] ecode,
		input logic [31:0] value, input logic [31:0] cx, input logic [31:0] cy);
		int gap;
		if ($urandom_range(0, 60) == 0)
			tx_steady = !tx_steady;
		gap = draw_wait(tx_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		event_type   <= etype;
		event_code   <= ecode;
		event_value  <= value;
		cursor_now_x <= cx;
		cursor_now_y <= cy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_event(etype, ecode, value, cx, cy);
		items_sent++;
	endtask

	task automatic send_quick(input logic [15:0] etype, input logic [15:0] ecode,
		input logic [31:0] value);
		send_event(etype, ecode, value, $urandom, $urandom);
	endtask

	// hold the sender until every due report is back and the pipeline is empty
	task automatic wait_for_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic program_screen(input logic [15:0] w, input logic [15:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_screen(w, h);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_position();
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 32767);
			1: return -$urandom_range(0, 32767);
			2: return $urandom_range(0, 65535);
			3: begin
				case ($urandom_range(0, 5))
					0: return 32'h0000_0000;
					1: return 32'h0000_7fff;
					2: return 32'h8000_0000;
					3: return 32'h7fff_ffff;
					4: return 32'hffff_ffff;
					default: return 32'hffff_8001;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_key_value();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_key_code();
		case ($urandom_range(0, 2))
			0: return CODE_BTN_LEFT;
			1: return CODE_BTN_RIGHT;
			default: return CODE_BTN_MIDDLE;
		endcase
	endfunction

	// axis and key updates followed by one sync report
	task automatic send_frame();
		int n;
		n = $urandom_range(0, 4);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0)
				send_quick(TYPE_ABS, ($urandom_range(0, 1) == 0) ? CODE_AXIS_X : CODE_AXIS_Y,
					pick_position());
			else
				send_quick(TYPE_KEY, pick_key_code(), pick_key_value());
		end
		send_quick(TYPE_SYN, CODE_SYN_REPORT, $urandom);
	endtask

	task automatic send_noise();
		logic [15:0] etype;
		logic [15:0] ecode;
		case ($urandom_range(0, 4))
			0: etype = TYPE_SYN;
			1: etype = TYPE_KEY;
			2: etype = TYPE_ABS;
			default: etype = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: ecode = 16'($urandom_range(0, 3));
			1: ecode = 16'($urandom_range(32'h010e, 32'h0114));
			default: ecode = 16'($urandom);
		endcase
		send_quick(etype, ecode, $urandom);
	endtask

	task automatic run_directed();
		// no position yet: cursor passes through
		send_event(TYPE_SYN, CODE_SYN_REPORT, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
		send_event(TYPE_SYN, CODE_SYN_REPORT, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_quick(TYPE_KEY, CODE_BTN_LEFT, 32'd1);
		send_quick(TYPE_KEY, CODE_BTN_RIGHT, 32'h8000_0000);
		send_quick(TYPE_KEY, CODE_BTN_MIDDLE, 32'hffff_ffff);
		send_event(TYPE_SYN, CODE_SYN_REPORT, 32'd0, 32'd0, 32'hffff_ffff);
		// unknown codes and types: ignored
		send_quick(TYPE_KEY, 16'h010f, 32'd1);
		send_quick(TYPE_KEY, 16'h0113, 32'd0);
		send_quick(TYPE_ABS, 16'h0002, 32'd5);
		send_quick(TYPE_ABS, 16'hffff, 32'd7);
		send_quick(TYPE_SYN, 16'h0001, 32'd0);
		send_quick(16'h0002, CODE_SYN_REPORT, 32'd0);
		send_quick(16'hffff, 16'hffff, 32'hffff_ffff);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		// one axis seen: the other reads as zero
		send_quick(TYPE_ABS, CODE_AXIS_Y, 32'h0000_7fff);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		send_quick(TYPE_ABS, CODE_AXIS_X, 32'h8000_0000);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		send_quick(TYPE_KEY, CODE_BTN_LEFT, 32'd0);
		send_quick(TYPE_KEY, CODE_BTN_MIDDLE, 32'd0);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		send_quick(TYPE_ABS, CODE_AXIS_X, 32'h7fff_ffff);
		send_quick(TYPE_ABS, CODE_AXIS_Y, 32'hffff_ffff);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		wait_for_reports();
		// widest screen wraps the quotient; zero height behaves as two
		program_screen(16'hffff, 16'd0);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		wait_for_reports();
		program_screen(16'd1, 16'hffff);
		send_quick(TYPE_ABS, CODE_AXIS_X, 32'hffff_8001);
		send_quick(TYPE_ABS, CODE_AXIS_Y, 32'h8000_0000);
		send_quick(TYPE_SYN, CODE_SYN_REPORT, 32'd0);
		wait_for_reports();
	endtask

	initial begin
		int target;
		int base;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_SCREEN_WIDTH;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		event_type   <= '0;
		event_code   <= '0;
		event_value  <= '0;
		cursor_now_x <= '0;
		cursor_now_y <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		base = items_sent;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_screen(16'hffff, 16'hffff);
				1: program_screen(16'd0, 16'd1);
				2: program_screen(16'd2, 16'd2);
				3: program_screen(16'd1024, 16'd768);
				4: program_screen(16'd1, 16'd0);
				default: program_screen(16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
			endcase
			target = base + (RANDOM_ITEMS * (phase + 1)) / PHASES;
			while (items_sent < target) begin
				if ($urandom_range(0, 6) == 0)
					send_noise();
				else
					send_frame();
			end
			wait_for_reports();
		end

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
